### hdl/czn_pkg.sv
// ----------------------------------------------------------------------------
// czn_pkg: shared definitions of the column z-score normalizer
// field widths, request codes, result status codes and the queued request type
// ----------------------------------------------------------------------------
`default_nettype none

package czn_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 1024;

	localparam int SAMPLE_W = 24;
	localparam int Z_W      = 32;
	localparam int LW_W     = 9;
	localparam int COLOUT_W = 8;
	localparam int ROWOUT_W = 10;
	localparam int STAT_W   = 3;
	localparam int MODE_W   = 2;
	localparam int MEAN_W   = 24;
	localparam int INV_W    = 32;

	// request codes carried on the input channel
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STS_ACCEPTED = 3'd0;
	localparam logic [STAT_W-1:0] STS_VALUE    = 3'd1;
	localparam logic [STAT_W-1:0] STS_PARTIAL  = 3'd2;
	localparam logic [STAT_W-1:0] STS_NO_ROWS  = 3'd3;
	localparam logic [STAT_W-1:0] STS_FULL     = 3'd4;
	localparam logic [STAT_W-1:0] STS_ZERO_SPR = 3'd5;
	localparam logic [STAT_W-1:0] STS_EMPTY    = 3'd6;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [MODE_W-1:0]          code;
		logic signed [SAMPLE_W-1:0] sample;
	} czn_op_t;

	typedef struct packed {
		logic push;
		logic full;
	} czn_push_t;

endpackage

`default_nettype wire

### hdl/czn_if.sv
// ----------------------------------------------------------------------------
// czn_if: request and result channels of the column z-score normalizer
// valid/ready channels, transfer when both are high at a rising edge
// ----------------------------------------------------------------------------
`default_nettype none

interface czn_in_if import czn_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface czn_out_if import czn_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [Z_W-1:0]      z_value;
	logic [COLOUT_W-1:0]        column;
	logic [ROWOUT_W-1:0]        row;
	logic                       end_of_row;
	logic                       last;
	logic [STAT_W-1:0]          status;

	modport source (output valid, output z_value, output column, output row,
		output end_of_row, output last, output status, input ready);
	modport sink   (input valid, input z_value, input column, input row,
		input end_of_row, input last, input status, output ready);
endinterface

`default_nettype wire

### hdl/czn_front.sv
// ----------------------------------------------------------------------------
// czn_front: request intake
// accepts requests while the queue has room, drops unknown codes
// ----------------------------------------------------------------------------
`default_nettype none

module czn_front import czn_pkg::*; (
	czn_in_if.sink    in_ch,
	input  wire logic q_full,
	output czn_push_t push_o,
	output czn_op_t   op_o
);

	logic known;

	assign in_ch.ready = !q_full;

	always_comb begin
		case (in_ch.mode)
			MODE_LOAD, MODE_READ, MODE_CLEAR: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign push_o.push = in_ch.valid && !q_full && known;
	assign push_o.full = q_full;
	assign op_o.code   = in_ch.mode;
	assign op_o.sample = in_ch.sample;

endmodule

`default_nettype wire

### hdl/czn_fifo.sv
// ----------------------------------------------------------------------------
// czn_fifo: short request queue between front and back
// small register queue, no push while full, else one push and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module czn_fifo import czn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  czn_push_t     push_i,
	input  czn_op_t       op_i,
	input  wire logic     pop,
	output czn_op_t       head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	czn_op_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_push;
	logic               do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign do_push = push_i.push && !push_i.full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= op_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/czn_div.sv
// ----------------------------------------------------------------------------
// czn_div: shared restoring divider
// one quotient bit per cycle, 32 bit divisor, done pulses with the quotient
// ----------------------------------------------------------------------------
`default_nettype none

module czn_div import czn_pkg::*; #(
	parameter int DVD_W = 57
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [31:0]      divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [31:0]       rem_q;
	logic [31:0]       dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [32:0]       trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= CNT_W'(DVD_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### hdl/czn_back.sv
// ----------------------------------------------------------------------------
// czn_back: request execution
// sample store, column sums, statistics pass and scoring, result register
// ----------------------------------------------------------------------------
`default_nettype none

module czn_back import czn_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [LW_W-1:0] cfg_data,
	input  czn_op_t              head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	czn_out_if.source            out_ch
);

	localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int WID_W   = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W   = $clog2(MAX_ROWS + 1);
	localparam int STORE_D = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W  = (STORE_D > 1) ? $clog2(STORE_D) : 1;
	localparam int SUM_W   = SAMPLE_W + ROW_W;
	localparam int SQ_W    = 2 * SAMPLE_W - 2 + ROW_W;
	localparam int DVD_W   = SQ_W;
	localparam int DIFF_W  = SAMPLE_W + 1;
	localparam int PROD_W  = DIFF_W + INV_W + 1;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LDACC = 5'd1;
	localparam logic [4:0] S_STRD  = 5'd2;
	localparam logic [4:0] S_STMN  = 5'd3;
	localparam logic [4:0] S_STMD  = 5'd4;
	localparam logic [4:0] S_STQD  = 5'd5;
	localparam logic [4:0] S_STSQ  = 5'd6;
	localparam logic [4:0] S_STID  = 5'd7;
	localparam logic [4:0] S_STWR  = 5'd8;
	localparam logic [4:0] S_RDMEM = 5'd9;
	localparam logic [4:0] S_RDSUB = 5'd10;
	localparam logic [4:0] S_RDMUL = 5'd11;
	localparam logic [4:0] S_RDRND = 5'd12;
	localparam logic [4:0] S_EMIT  = 5'd13;

	logic [4:0]               state_q;
	logic [WID_W-1:0]         width_q;
	logic [COL_W-1:0]         fill_col_q;
	logic [ROW_W-1:0]         full_rows_q;
	logic [ADDR_W:0]          wr_addr_q;
	logic [ADDR_W:0]          rd_pos_q;
	logic [COL_W-1:0]         rd_col_q;
	logic [ROW_W-1:0]         rd_row_q;
	logic                     stats_rdy_q;
	logic [MAX_COLUMNS-1:0]   sum_vld_q;
	logic [COL_W-1:0]         stat_col_q;
	czn_op_t                  op_q;

	logic signed [SAMPLE_W-1:0] store_mem [STORE_D];
	logic signed [SUM_W-1:0]    sum_mem   [MAX_COLUMNS];
	logic [SQ_W-1:0]            sq_mem    [MAX_COLUMNS];
	logic signed [MEAN_W-1:0]   mean_mem  [MAX_COLUMNS];
	logic [INV_W-1:0]           inv_mem   [MAX_COLUMNS];

	logic signed [SUM_W-1:0]    sum_rd_q;
	logic [SQ_W-1:0]            sq_rd_q;
	logic                       vld_rd_q;
	logic signed [SAMPLE_W-1:0] x_rd_q;
	logic signed [MEAN_W-1:0]   mean_rd_q;
	logic [INV_W-1:0]           inv_rd_q;

	logic signed [2*SAMPLE_W-1:0] sq_s1;
	logic [SQ_W-1:0]            sq_hold_q;
	logic                       neg_q;
	logic signed [MEAN_W-1:0]   mean_q;
	logic signed [2*MEAN_W-1:0] mm_q;
	logic [63:0]                sv_q;
	logic [63:0]                sr_q;
	logic [63:0]                sb_q;
	logic [INV_W-1:0]           inv_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [PROD_W-1:0]   prod_q;

	logic signed [Z_W-1:0]      res_z_q;
	logic [COLOUT_W-1:0]        res_col_q;
	logic [ROWOUT_W-1:0]        res_row_q;
	logic                       res_eor_q;
	logic                       res_last_q;
	logic [STAT_W-1:0]          res_sts_q;

	logic                       out_vld_q;
	logic signed [Z_W-1:0]      out_z_q;
	logic [COLOUT_W-1:0]        out_col_q;
	logic [ROWOUT_W-1:0]        out_row_q;
	logic                       out_eor_q;
	logic                       out_last_q;
	logic [STAT_W-1:0]          out_sts_q;

	logic                       take;
	logic                       emit_go;
	logic                       is_full;
	logic                       st_we;
	logic                       sum_re;
	logic [COL_W-1:0]           sum_ra;
	logic signed [SUM_W-1:0]    new_sum;
	logic [SQ_W-1:0]            new_sq;
	logic [WID_W-1:0]           last_col;
	logic signed [SUM_W-1:0]    s_cur;
	logic [SUM_W-1:0]           s_abs;
	logic                       div_start;
	logic [DVD_W-1:0]           div_dvd;
	logic [31:0]                div_dvs;
	logic                       div_busy;
	logic                       div_done;
	logic [DVD_W-1:0]           div_quo;
	logic signed [63:0]         var_c;
	logic [63:0]                sqrt_rb;
	logic [PROD_W-1:0]          z_mag;
	logic [PROD_W:0]            z_rnd;
	logic signed [Z_W-1:0]      z_sat;
	logic [WID_W-1:0]           cfg_w;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_w = WID_W'(1);
		end else if (int'(cfg_data) > MAX_COLUMNS) begin
			cfg_w = WID_W'(MAX_COLUMNS);
		end else begin
			cfg_w = WID_W'(cfg_data);
		end
	end

	assign take     = (state_q == S_IDLE) && !q_empty;
	assign q_pop    = take;
	assign emit_go  = (state_q == S_EMIT) && !cfg_we && (!out_vld_q || out_ch.ready);
	assign is_full  = (full_rows_q == ROW_W'(MAX_ROWS));
	assign last_col = width_q - 1'b1;
	assign st_we    = take && (head.code == MODE_LOAD) && !is_full;
	assign sum_re   = st_we || (state_q == S_STRD);
	assign sum_ra   = (state_q == S_STRD) ? stat_col_q : fill_col_q;
	assign new_sum  = (vld_rd_q ? sum_rd_q : '0) + SUM_W'(op_q.sample);
	assign new_sq   = (vld_rd_q ? sq_rd_q : '0) + SQ_W'($unsigned(sq_s1));
	assign s_cur    = vld_rd_q ? sum_rd_q : '0;
	assign s_abs    = s_cur[SUM_W-1] ? SUM_W'(-s_cur) : SUM_W'(s_cur);
	assign var_c    = $signed(64'(div_quo)) - 64'(mm_q);
	assign sqrt_rb  = sr_q + sb_q;

	// divider requests: mean, mean square, reciprocal spread
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = 32'(full_rows_q);
		case (state_q)
			S_STMN: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(s_abs) + DVD_W'(full_rows_q >> 1);
			end
			S_STMD: begin
				div_start = div_done;
				div_dvd   = sq_hold_q;
			end
			S_STSQ: begin
				div_start = (sb_q == '0) && (sr_q != '0);
				div_dvd   = DVD_W'(64'h100_0000_0000) + DVD_W'(sr_q >> 1);
				div_dvs   = sr_q[31:0];
			end
			default: div_start = 1'b0;
		endcase
	end

	czn_div #(.DVD_W(DVD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// rounding and saturation of the scaled difference
	always_comb begin
		z_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		z_rnd = ((PROD_W+1)'(z_mag) + (PROD_W+1)'(128)) >> 8;
		if (prod_q[PROD_W-1]) begin
			z_sat = (z_rnd > (PROD_W+1)'(33'h0_8000_0000)) ? $signed(32'h8000_0000)
				: $signed(-z_rnd[31:0]);
		end else begin
			z_sat = (z_rnd > (PROD_W+1)'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
				: $signed(z_rnd[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[wr_addr_q[ADDR_W-1:0]] <= head.sample;
		end
		if (state_q == S_RDMEM) begin
			x_rd_q <= store_mem[rd_pos_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_ra];
			sq_rd_q  <= sq_mem[sum_ra];
		end
		if (state_q == S_LDACC) begin
			sum_mem[fill_col_q] <= new_sum;
			sq_mem[fill_col_q]  <= new_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STWR) begin
			mean_mem[stat_col_q] <= mean_q;
			inv_mem[stat_col_q]  <= inv_q;
		end
		if (state_q == S_RDMEM) begin
			mean_rd_q <= mean_mem[rd_col_q];
			inv_rd_q  <= inv_mem[rd_col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WID_W'(1);
			fill_col_q  <= '0;
			full_rows_q <= '0;
			wr_addr_q   <= '0;
			rd_pos_q    <= '0;
			rd_col_q    <= '0;
			rd_row_q    <= '0;
			stats_rdy_q <= 1'b0;
			sum_vld_q   <= '0;
			stat_col_q  <= '0;
			op_q        <= '0;
			vld_rd_q    <= 1'b0;
			sq_s1       <= '0;
			sq_hold_q   <= '0;
			neg_q       <= 1'b0;
			mean_q      <= '0;
			mm_q        <= '0;
			sv_q        <= '0;
			sr_q        <= '0;
			sb_q        <= '0;
			inv_q       <= '0;
			diff_q      <= '0;
			prod_q      <= '0;
			res_z_q     <= '0;
			res_col_q   <= '0;
			res_row_q   <= '0;
			res_eor_q   <= 1'b0;
			res_last_q  <= 1'b0;
			res_sts_q   <= STS_ACCEPTED;
			out_vld_q   <= 1'b0;
			out_z_q     <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_eor_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_sts_q   <= STS_ACCEPTED;
		end else begin
			// a new result replaces the taken one, else a taken one empties the register
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (sum_re) begin
				vld_rd_q <= sum_vld_q[sum_ra];
			end
			if (cfg_we) begin
				width_q     <= cfg_w;
				fill_col_q  <= '0;
				full_rows_q <= '0;
				wr_addr_q   <= '0;
				rd_pos_q    <= '0;
				rd_col_q    <= '0;
				rd_row_q    <= '0;
				stats_rdy_q <= 1'b0;
				sum_vld_q   <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (take) begin
							op_q       <= head;
							res_z_q    <= '0;
							res_col_q  <= '0;
							res_row_q  <= '0;
							res_eor_q  <= 1'b0;
							res_last_q <= 1'b0;
							state_q    <= S_EMIT;
							case (head.code)
								MODE_LOAD: begin
									if (is_full) begin
										res_sts_q <= STS_FULL;
									end else begin
										sq_s1   <= head.sample * head.sample;
										state_q <= S_LDACC;
									end
								end
								MODE_READ: begin
									if (fill_col_q != '0) begin
										res_sts_q <= STS_PARTIAL;
									end else if (full_rows_q == '0) begin
										res_sts_q <= STS_NO_ROWS;
									end else if (rd_pos_q >= wr_addr_q) begin
										res_sts_q <= STS_EMPTY;
									end else if (!stats_rdy_q) begin
										stat_col_q <= '0;
										state_q    <= S_STRD;
									end else begin
										state_q <= S_RDMEM;
									end
								end
								default: begin
									// clear and restart
									res_sts_q   <= STS_ACCEPTED;
									fill_col_q  <= '0;
									full_rows_q <= '0;
									wr_addr_q   <= '0;
									rd_pos_q    <= '0;
									rd_col_q    <= '0;
									rd_row_q    <= '0;
									stats_rdy_q <= 1'b0;
									sum_vld_q   <= '0;
								end
							endcase
						end
					end
					S_LDACC: begin
						sum_vld_q[fill_col_q] <= 1'b1;
						res_col_q   <= COLOUT_W'(fill_col_q);
						res_row_q   <= ROWOUT_W'(full_rows_q);
						res_eor_q   <= (WID_W'(fill_col_q) == last_col);
						res_sts_q   <= STS_ACCEPTED;
						stats_rdy_q <= 1'b0;
						wr_addr_q   <= wr_addr_q + 1'b1;
						if (WID_W'(fill_col_q) == last_col) begin
							fill_col_q  <= '0;
							full_rows_q <= full_rows_q + 1'b1;
						end else begin
							fill_col_q <= fill_col_q + 1'b1;
						end
						state_q <= S_EMIT;
					end
					S_STRD: begin
						state_q <= S_STMN;
					end
					S_STMN: begin
						sq_hold_q <= vld_rd_q ? sq_rd_q : '0;
						neg_q     <= s_cur[SUM_W-1];
						state_q   <= S_STMD;
					end
					S_STMD: begin
						if (div_done) begin
							mean_q  <= neg_q ? -div_quo[MEAN_W-1:0] : div_quo[MEAN_W-1:0];
							state_q <= S_STQD;
						end
					end
					S_STQD: begin
						mm_q <= mean_q * mean_q;
						if (div_done) begin
							sv_q    <= var_c[63] ? '0 : {var_c[47:0], 16'b0};
							sr_q    <= '0;
							sb_q    <= 64'h4000_0000_0000_0000;
							state_q <= S_STSQ;
						end
					end
					S_STSQ: begin
						if (sb_q != '0) begin
							if (sv_q >= sqrt_rb) begin
								sv_q <= sv_q - sqrt_rb;
								sr_q <= (sr_q >> 1) + sb_q;
							end else begin
								sr_q <= sr_q >> 1;
							end
							sb_q <= sb_q >> 2;
						end else if (sr_q == '0) begin
							inv_q   <= '0;
							state_q <= S_STWR;
						end else begin
							state_q <= S_STID;
						end
					end
					S_STID: begin
						if (div_done) begin
							inv_q   <= (div_quo[DVD_W-1:INV_W] != '0) ? '1
								: div_quo[INV_W-1:0];
							state_q <= S_STWR;
						end
					end
					S_STWR: begin
						if (WID_W'(stat_col_q) == last_col) begin
							stats_rdy_q <= 1'b1;
							state_q     <= S_RDMEM;
						end else begin
							stat_col_q <= stat_col_q + 1'b1;
							state_q    <= S_STRD;
						end
					end
					S_RDMEM: begin
						state_q <= S_RDSUB;
					end
					S_RDSUB: begin
						diff_q  <= DIFF_W'(x_rd_q) - DIFF_W'(mean_rd_q);
						state_q <= S_RDMUL;
					end
					S_RDMUL: begin
						prod_q  <= diff_q * $signed({1'b0, inv_rd_q});
						state_q <= S_RDRND;
					end
					S_RDRND: begin
						res_z_q    <= (inv_rd_q == '0) ? '0 : z_sat;
						res_sts_q  <= (inv_rd_q == '0) ? STS_ZERO_SPR : STS_VALUE;
						res_col_q  <= COLOUT_W'(rd_col_q);
						res_row_q  <= ROWOUT_W'(rd_row_q);
						res_eor_q  <= (WID_W'(rd_col_q) == last_col);
						res_last_q <= (rd_pos_q == wr_addr_q - 1'b1);
						rd_pos_q   <= rd_pos_q + 1'b1;
						if (WID_W'(rd_col_q) == last_col) begin
							rd_col_q <= '0;
							rd_row_q <= rd_row_q + 1'b1;
						end else begin
							rd_col_q <= rd_col_q + 1'b1;
						end
						state_q <= S_EMIT;
					end
					S_EMIT: begin
						if (emit_go) begin
							out_z_q    <= res_z_q;
							out_col_q  <= res_col_q;
							out_row_q  <= res_row_q;
							out_eor_q  <= res_eor_q;
							out_last_q <= res_last_q;
							out_sts_q  <= res_sts_q;
							state_q    <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.z_value    = out_z_q;
	assign out_ch.column     = out_col_q;
	assign out_ch.row        = out_row_q;
	assign out_ch.end_of_row = out_eor_q;
	assign out_ch.last       = out_last_q;
	assign out_ch.status     = out_sts_q;

	// a load never writes past the store
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (full_rows_q < ROW_W'(MAX_ROWS)))
		else $error("store write with no room");

	// fill column stays inside the row
	a_fill_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(fill_col_q) < width_q)
		else $error("fill column outside the row");

	// reads never run ahead of loads
	a_read_behind: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pos_q <= wr_addr_q)
		else $error("read position past loaded data");

	// divider is never restarted while working
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule

`default_nettype wire

### hdl/column_zscore_normalizer_core.sv
// ----------------------------------------------------------------------------
// column_zscore_normalizer_core: per-column z-score standardization
// loads a matrix row by row, returns each value as (x - mean) / sigma
// ----------------------------------------------------------------------------
// usage
//   in_ch carries requests: mode 0 loads sample (Q11.12), mode 1 reads the
//   next standardized value, mode 2 clears; mode 3 is taken and ignored
//   out_ch gives one result per load, read or clear: z_value (Q7.24),
//   column, row, end_of_row, last and status
//   cfg_we/cfg_data write the row width; a write also clears the loaded matrix
// timing
//   the front takes a request per cycle into a four-entry queue while it
//   has room; the back works one request at a time: a load passes an
//   accumulate state, an error or clear goes straight to the result, and a
//   read with statistics ready passes single-port store read, subtract,
//   multiply and round stages; the first read after loading runs a
//   statistics pass over every column on the divider and a square root
// reset and stall
//   reset empties the queue and clears counters and column-sum valid bits at
//   once; no clearing pass runs
//   a stalled receiver holds the result register; the queue keeps taking
//   requests until full, then in_ch.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module column_zscore_normalizer_core import czn_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	czn_in_if.sink               in_ch,
	czn_out_if.source            out_ch,
	input  wire logic            cfg_we,
	input  wire logic [LW_W-1:0] cfg_data
);

	// front to queue
	czn_push_t push;
	czn_op_t   push_op;
	// queue to back
	czn_op_t   head;
	logic      q_empty;
	logic      q_full;
	logic      q_pop;

	// request intake and classification
	czn_front u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push_o (push),
		.op_o   (push_op)
	);

	// decouples intake from execution
	czn_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (push),
		.op_i   (push_op),
		.pop    (q_pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// execution: store, sums, statistics, scoring, result register
	czn_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.head     (head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

### sim/column_zscore_normalizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// column_zscore_normalizer_core_tb: self-checking bench of the z-score core
// drives load, read and clear requests with random idling on both channels,
// predicts every result from a bit-exact software copy of the column
// statistics and compares each result field by field in arrival order
// ----------------------------------------------------------------------------

module column_zscore_normalizer_core_tb;
	import czn_pkg::*;

	localparam int IDLE_LIMIT  = 400000;  // long enough for a stats pass at 256 columns
	localparam int SETTLE      = 40;

	typedef struct packed {
		logic signed [Z_W-1:0] z_value;
		logic [COLOUT_W-1:0]   column;
		logic [ROWOUT_W-1:0]   row;
		logic                  end_of_row;
		logic                  last;
		logic [STAT_W-1:0]     status;
	} zres_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [LW_W-1:0] cfg_data;

	czn_in_if  in_ch ();
	czn_out_if out_ch ();

	column_zscore_normalizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// ------------------------------------------------------------------
	// shadow copy of the matrix and its column statistics
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] sh_store [int];
	longint          sh_sum [MAX_COLUMNS_DEF];
	longint unsigned sh_sqsum [MAX_COLUMNS_DEF];
	longint          sh_mean [MAX_COLUMNS_DEF];
	longint unsigned sh_inv [MAX_COLUMNS_DEF];
	int unsigned sh_fill, sh_rows, sh_rdpos, sh_width;
	bit          sh_stats_ok;

	zres_t zres_q [$];       // results still owed by the block
	int    err_cnt;
	int    item_cnt;
	int    tx_idle, rx_idle; // idle percentages of sender and receiver
	int    hold_cycles;      // receiver hold-off request

	function automatic void shadow_clear();
		for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
			sh_sum[c]   = 0;
			sh_sqsum[c] = 0;
		end
		sh_fill     = 0;
		sh_rows     = 0;
		sh_rdpos    = 0;
		sh_stats_ok = 0;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// mean rounds ties away from zero, variance clamps at zero,
	// reciprocal sigma rounds ties up and saturates to 32 bits
	function automatic void column_stats();
		longint          s, m, v;
		longint unsigned n, mag, sig, inv;
		n = sh_rows;
		for (int c = 0; c < sh_width; c++) begin
			s   = sh_sum[c];
			mag = (s < 0) ? -s : s;
			m   = (mag + n / 2) / n;
			if (s < 0) m = -m;
			sh_mean[c] = m;
			v = longint'(sh_sqsum[c] / n) - m * m;
			if (v < 0) v = 0;
			sig = int_root(longint'(v) << 16);
			if (sig == 0)
				sh_inv[c] = 0;
			else begin
				inv = ((64'd1 << 40) + sig / 2) / sig;
				if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
				sh_inv[c] = inv;
			end
		end
		sh_stats_ok = 1;
	endfunction

	// expected result of one accepted request; returns 0 when none is due
	function automatic bit zscore_predict(logic [MODE_W-1:0] md,
			logic signed [SAMPLE_W-1:0] x, output zres_t r);
		int unsigned total, pos, col;
		longint diff, prod, z;
		longint unsigned mag;
		r = '0;
		case (md)
			MODE_LOAD: begin
				if (sh_rows >= MAX_ROWS_DEF) begin
					r.status = STS_FULL;
					return 1;
				end
				col = sh_fill;
				sh_store[sh_rows * sh_width + col] = x;
				sh_sum[col]   += x;
				sh_sqsum[col] += longint'(x) * longint'(x);
				sh_stats_ok = 0;
				r.column     = col;
				r.row        = sh_rows;
				r.end_of_row = (col == sh_width - 1);
				r.status     = STS_ACCEPTED;
				sh_fill++;
				if (sh_fill >= sh_width) begin
					sh_fill = 0;
					sh_rows++;
				end
				return 1;
			end
			MODE_READ: begin
				// partial row is tested before no rows
				if (sh_fill != 0) begin
					r.status = STS_PARTIAL;
					return 1;
				end
				if (sh_rows == 0) begin
					r.status = STS_NO_ROWS;
					return 1;
				end
				total = sh_rows * sh_width;
				if (sh_rdpos >= total) begin
					r.status = STS_EMPTY;
					return 1;
				end
				if (!sh_stats_ok) column_stats();
				pos = sh_rdpos++;
				col = pos % sh_width;
				r.column     = col;
				r.row        = pos / sh_width;
				r.end_of_row = (col == sh_width - 1);
				r.last       = (pos == total - 1);
				if (sh_inv[col] == 0) begin
					r.status = STS_ZERO_SPR;
					return 1;
				end
				diff = longint'(sh_store[pos]) - sh_mean[col];
				prod = diff * longint'(sh_inv[col]);
				mag  = (prod < 0) ? -prod : prod;
				mag  = (mag + 128) >> 8;
				if (prod < 0)
					z = (mag > 64'h8000_0000) ? -64'sd2147483648 : -longint'(mag);
				else
					z = (mag > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(mag);
				r.z_value = z[31:0];
				r.status  = STS_VALUE;
				return 1;
			end
			MODE_CLEAR: begin
				shadow_clear();
				r.status = STS_ACCEPTED;
				return 1;
			end
			default: return 0;  // mode 3 is swallowed
		endcase
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic send_req(logic [MODE_W-1:0] md, logic signed [SAMPLE_W-1:0] x);
		zres_t r;
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.mode   <= md;
		in_ch.sample <= x;
		@(posedge clk iff in_ch.ready);
		if (zscore_predict(md, x, r)) zres_q.push_back(r);
		item_cnt++;
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic set_width(logic [LW_W-1:0] v);
		stop_sending();
		wait (zres_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_width = (v < 1) ? 1 : (v > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : v;
		shadow_clear();
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(5))
			0:       return $signed(24'(24'h800000 + $urandom_range(3)));
			1:       return $signed(24'(24'h7FFFFF - $urandom_range(3)));
			2:       return $signed(24'($urandom_range(32)) - 24'sd16);
			default: return $signed(24'($urandom));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result side: random ready, hold-off stretches, in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		zres_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (zres_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("%0t: result with no request pending, status %0d",
						$realtime, out_ch.status);
			end else begin
				e = zres_q.pop_front();
				if (out_ch.z_value !== e.z_value || out_ch.column !== e.column ||
						out_ch.row !== e.row || out_ch.end_of_row !== e.end_of_row ||
						out_ch.last !== e.last || out_ch.status !== e.status) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("%0t: mismatch exp z=%h col=%0d row=%0d eor=%b last=%b st=%0d",
							$realtime, e.z_value, e.column, e.row, e.end_of_row,
							e.last, e.status);
						$display("    got z=%h col=%0d row=%0d eor=%b last=%b st=%0d",
							out_ch.z_value, out_ch.column, out_ch.row,
							out_ch.end_of_row, out_ch.last, out_ch.status);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	int quiet_cnt;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cnt <= 0;
		else if (arst_n) begin
			quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// whole rows of random samples at the current width: loads only
	task automatic load_rows(int rows);
		for (int i = 0; i < rows * sh_width; i++) send_req(MODE_LOAD, rand_sample());
	endtask

	task automatic read_n(int n);
		for (int i = 0; i < n; i++) send_req(MODE_READ, '0);
	endtask

	task automatic test_directed();
		set_width(9'd1);
		send_req(MODE_READ, '0);               // no rows
		send_req(MODE_LOAD, 24'sh123456);
		send_req(MODE_READ, '0);               // single row: zero spread
		send_req(MODE_READ, '0);               // nothing left
		send_req(2'd3, 24'sh7FFFFF);           // ignored code
		send_req(MODE_CLEAR, '0);
		// rounding drives the variance negative: 1 and 2
		send_req(MODE_LOAD, 24'sd1);
		send_req(MODE_LOAD, 24'sd2);
		read_n(2);
		set_width(9'd3);
		send_req(MODE_LOAD, 24'sh800000);
		send_req(MODE_LOAD, 24'sh7FFFFF);
		send_req(MODE_READ, '0);               // partial row
		send_req(MODE_LOAD, 24'sd0);
		send_req(MODE_LOAD, 24'sh7FFFFF);
		send_req(MODE_LOAD, 24'sh800000);
		send_req(MODE_LOAD, -24'sd1);
		read_n(2);
		send_req(MODE_LOAD, 24'sd5);           // load after reading began
		send_req(MODE_LOAD, 24'sd6);
		send_req(MODE_LOAD, 24'sd7);
		read_n(8);
	endtask

	// register extremes: 0 clamps to one column, 511 to the full width
	task automatic test_width_extremes();
		set_width(9'd0);
		load_rows(2);
		read_n(3);
		set_width(9'h1FF);
		for (int i = 0; i < 5; i++) send_req(MODE_LOAD, rand_sample());
		send_req(MODE_READ, '0);
		set_width(9'd256);
		load_rows(1);
		read_n(sh_width + 1);
	endtask

	// receiver stalls long while requests keep coming
	task automatic test_backpressure();
		set_width(9'd4);
		hold_cycles = 300;
		load_rows(5);
		read_n(21);
	endtask

	task automatic random_phase(int quota);
		int goal;
		goal = item_cnt + quota;
		while (item_cnt < goal) begin
			if ($urandom_range(3) == 0) set_width(9'($urandom_range(1, 8)));
			else send_req(MODE_CLEAR, '0);
			load_rows($urandom_range(1, 5));
			if ($urandom_range(3) == 0) begin
				read_n($urandom_range(1, sh_rows * sh_width));
				load_rows(1);
			end
			if ($urandom_range(4) == 0) send_req(MODE_LOAD, rand_sample());
			read_n(sh_rows * sh_width + $urandom_range(2));
			// noise
			for (int k = $urandom_range(3); k > 0; k--)
				send_req(2'($urandom), rand_sample());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.mode   = MODE_LOAD;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		err_cnt      = 0;
		item_cnt     = 0;
		hold_cycles  = 0;
		quiet_cnt    = 0;
		tx_idle      = 25;
		rx_idle      = 46;
		sh_width     = 1;
		shadow_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_width_extremes();
		test_backpressure();
		random_phase(90);
		tx_idle = 46;
		rx_idle = 25;
		random_phase(75);
		tx_idle = 0;
		rx_idle = 0;
		random_phase(75);

		stop_sending();
		wait (zres_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
